// File: src/hps_pkg.sv
// Shared types, constants and helpers for the hex pattern byte search block.
// No dependencies; used by the match cell and the top level.
package hps_pkg;

   localparam int MAX_BYTES = 64;
   localparam int IDX_W     = $clog2(MAX_BYTES);
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   typedef enum logic [1:0] {
      OP_HEX_CHAR  = 2'd0,
      OP_PAT_END   = 2'd1,
      OP_DATA_BYTE = 2'd2,
      OP_DATA_END  = 2'd3
   } op_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_RESULT = 1'b1;

   // Broadcast from the top level to every cell of the match row.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_index;
      logic [7:0]       wr_byte;
      logic             shift_en;
      logic             clear;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= "0" && ch <= "9") begin
         r = {1'b1, 4'(ch - "0")};
      end else if (ch >= "a" && ch <= "f") begin
         r = {1'b1, 4'(ch - "a" + 8'd10)};
      end else if (ch >= "A" && ch <= "F") begin
         r = {1'b1, 4'(ch - "A" + 8'd10)};
      end
      return r;
   endfunction

endpackage

// File: src/hps_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing; op codes live in hps_pkg.
interface hps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data;

   modport source (output valid, output op, output data, input ready);
   modport sink   (input valid, input op, input data, output ready);
endinterface

interface hps_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       pattern_ok;
   logic [6:0] pattern_bytes_used;
   logic       found;

   modport source (output valid, output kind, output pattern_ok,
                   output pattern_bytes_used, output found, input ready);
   modport sink   (input valid, input kind, input pattern_ok,
                   input pattern_bytes_used, input found, output ready);
endinterface

// File: src/hps_cell.sv
// One position of the shift-and match row: a pattern byte and its match bit.
// Depends on hps_pkg (cell_ctrl_type, widths).
module hps_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [hps_pkg::IDX_W-1:0]  cell_index,
   input  hps_pkg::cell_ctrl_type     ctrl,
   input  logic                       prev_match,
   output logic                       match_ff,
   output logic                       hit
);

   logic [7:0] store_ff;
   logic       match_in;
   logic       eq;
   logic       is_last;

   assign eq      = (store_ff == ctrl.data_byte);
   assign is_last = (ctrl.count == hps_pkg::CNT_W'(cell_index) + hps_pkg::CNT_W'(1));

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift_en) begin
         match_in = prev_match && eq;
      end
   end

   // whole pattern matched when the last active position lights up
   assign hit = ctrl.shift_en && prev_match && eq && is_last;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && ctrl.wr_index == cell_index) begin
         store_ff <= ctrl.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

// File: src/hex_pattern_byte_search.sv
// Hex pattern byte search. A pattern is loaded as ASCII hex characters (either case), two per
// byte, up to 64 bytes, and closed by a pattern end beat that returns a status response. Data
// bytes then shift through a row of 64 match cells, each holding one pattern byte and one match
// bit; a data end beat returns whether the full pattern occurred since the last end beat. Every
// request beat is handled as it is accepted, so one beat per clock is sustained; the row of cells
// updates all positions in parallel on each data byte. Responses sit in an output register, and the
// request side stalls only while that register holds a response the sink has not taken.
// Depends on hps_pkg, hps_if.sv and hps_cell.
module hex_pattern_byte_search (
   input  logic      clock,
   input  logic      reset,
   hps_req_if.sink   req_chan,
   hps_rsp_if.source rsp_chan
);

   localparam int MAX   = hps_pkg::MAX_BYTES;
   localparam int CNT_W = hps_pkg::CNT_W;
   localparam int IDX_W = hps_pkg::IDX_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [3:0]       held_ff, held_in;
   logic             waiting_ff, waiting_in;
   logic             bad_ff, bad_in;
   logic             open_ff, open_in;
   logic             valid_ff, valid_in;
   logic             hit_seen_ff, hit_seen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [CNT_W-1:0] rsp_used_ff, rsp_used_in;
   logic             rsp_found_ff, rsp_found_in;

   logic             fire;
   logic [CNT_W-1:0] eff_count;
   logic             eff_waiting;
   logic             eff_bad;
   logic [4:0]       nib;
   logic             rsp_load;
   hps_pkg::cell_ctrl_type ctrl;

   logic [MAX-1:0]   match_w;
   logic [MAX-1:0]   hit_w;
   logic             any_hit;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;
   assign nib            = hps_pkg::hex_nibble(req_chan.data);
   assign any_hit        = |hit_w;

   // a closed pattern reads as empty to the next hex char or pattern end; a hex char reopens it
   assign eff_count   = open_ff ? count_ff : '0;
   assign eff_waiting = open_ff && waiting_ff;
   assign eff_bad     = open_ff && bad_ff;

   always_comb begin
      count_in      = count_ff;
      held_in       = held_ff;
      waiting_in    = waiting_ff;
      bad_in        = bad_ff;
      open_in       = open_ff;
      valid_in      = valid_ff;
      hit_seen_in   = hit_seen_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_found_in  = rsp_found_ff;
      ctrl          = '0;
      ctrl.wr_index = eff_count[IDX_W-1:0];
      ctrl.wr_byte  = {held_ff, nib[3:0]};
      ctrl.data_byte = req_chan.data;
      ctrl.count    = count_ff;

      if (fire) begin
         case (hps_pkg::op_type'(req_chan.op))
            hps_pkg::OP_HEX_CHAR: begin
               if (!open_ff) begin
                  count_in    = '0;
                  waiting_in  = 1'b0;
                  bad_in      = 1'b0;
                  valid_in    = 1'b0;
                  open_in     = 1'b1;
                  hit_seen_in = 1'b0;
                  ctrl.clear  = 1'b1;
               end
               if (!eff_bad) begin
                  if (!nib[4]) begin
                     bad_in = 1'b1;
                  end else if (!eff_waiting) begin
                     held_in    = nib[3:0];
                     waiting_in = 1'b1;
                  end else begin
                     waiting_in = 1'b0;
                     if (eff_count >= CNT_W'(MAX)) begin
                        bad_in = 1'b1;
                     end else begin
                        ctrl.wr_en = 1'b1;
                        count_in   = eff_count + CNT_W'(1);
                     end
                  end
               end
            end
            hps_pkg::OP_PAT_END: begin
               count_in     = eff_count;
               waiting_in   = eff_waiting;
               bad_in       = eff_bad;
               valid_in     = !eff_bad && !eff_waiting && (eff_count != '0);
               open_in      = 1'b0;
               hit_seen_in  = 1'b0;
               ctrl.clear   = 1'b1;
               rsp_load     = 1'b1;
               rsp_kind_in  = hps_pkg::KIND_STATUS;
               rsp_ok_in    = !eff_bad && !eff_waiting && (eff_count != '0);
               rsp_used_in  = eff_count;
               rsp_found_in = 1'b0;
            end
            hps_pkg::OP_DATA_BYTE: begin
               if (valid_ff) begin
                  ctrl.shift_en = 1'b1;
                  if (any_hit) begin
                     hit_seen_in = 1'b1;
                  end
               end
            end
            hps_pkg::OP_DATA_END: begin
               rsp_load     = 1'b1;
               rsp_kind_in  = hps_pkg::KIND_RESULT;
               rsp_ok_in    = valid_ff;
               rsp_used_in  = count_ff;
               rsp_found_in = valid_ff && hit_seen_ff;
               hit_seen_in  = 1'b0;
               ctrl.clear   = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   genvar k;
   generate
      for (k = 0; k < MAX; k++) begin : g_cell
         logic prev;
         if (k == 0) begin : g_first
            assign prev = 1'b1;
         end else begin : g_rest
            assign prev = match_w[k-1];
         end
         hps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(k)),
            .ctrl       (ctrl),
            .prev_match (prev),
            .match_ff   (match_w[k]),
            .hit        (hit_w[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         held_ff      <= '0;
         waiting_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         open_ff      <= 1'b0;
         valid_ff     <= 1'b0;
         hit_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         held_ff      <= held_in;
         waiting_ff   <= waiting_in;
         bad_ff       <= bad_in;
         open_ff      <= open_in;
         valid_ff     <= valid_in;
         hit_seen_ff  <= hit_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_used_ff  <= rsp_used_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.kind               = rsp_kind_ff;
   assign rsp_chan.pattern_ok         = rsp_ok_ff;
   assign rsp_chan.pattern_bytes_used = rsp_used_ff;
   assign rsp_chan.found              = rsp_found_ff;

   a_valid_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (count_ff != '0) && !open_ff)
      else $error("valid pattern with zero length or still open");

   a_found_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_ok_ff && (rsp_kind_ff == hps_pkg::KIND_RESULT))
      else $error("found reported without a valid pattern");

   a_end_clears_hit: assert property (@(posedge clock) disable iff (reset)
      fire && (req_chan.op == hps_pkg::OP_DATA_END) |=> !hit_seen_ff && (match_w == '0))
      else $error("match state not cleared after data end");

   a_bytes_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> !any_hit)
      else $error("hit raised without a valid pattern");

endmodule

// File: tb/sv/tb_hex_pattern_byte_search.sv
// Self-checking testbench for hex_pattern_byte_search: a beat-level predictor
// of pattern decode and shift-and search, valid/ready drivers with random stalls.
// Depends on hps_pkg, hps_if.sv and the hex_pattern_byte_search RTL.
module tb_hex_pattern_byte_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int BEAT_TARGET  = 1750;
   localparam int STEADY_BEATS = 250;

   typedef logic [7:0] byte_list_type[$];

   typedef struct {
      logic       kind;
      logic       ok;
      logic [6:0] used;
      logic       found;
   } search_report_type;

   logic clock;
   logic reset;

   hps_req_if req_bus ();
   hps_rsp_if rsp_bus ();

   hex_pattern_byte_search u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   search_report_type pending_reports[$];
   int                failures;
   int                beats_sent;
   int                idle_cycles;
   bit                steady;

   // predictor state
   logic [7:0]                   pat_bytes [hps_pkg::MAX_BYTES];
   int                           pat_len;
   logic [3:0]                   half_nibble;
   bit                           half_pending;
   bit                           pat_broken;
   bit                           pat_loading;
   bit                           pat_armed;
   logic [hps_pkg::MAX_BYTES-1:0] match_bits;
   bit                           hit_flag;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [4:0] char_value(input logic [7:0] c);
      if (c inside {["0":"9"]}) return {1'b1, 4'(c - "0")};
      if (c inside {["a":"f"]}) return {1'b1, 4'(c - "a" + 8'd10)};
      if (c inside {["A":"F"]}) return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return "0" + 8'(n);
      return (upper ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   function automatic void clear_match();
      match_bits = '0;
      hit_flag   = 1'b0;
   endfunction

   function automatic void start_pattern();
      pat_len      = 0;
      half_nibble  = 4'd0;
      half_pending = 1'b0;
      pat_broken   = 1'b0;
      pat_armed    = 1'b0;
      pat_loading  = 1'b1;
      clear_match();
   endfunction

   function automatic void predict_beat(input hps_pkg::op_type op, input logic [7:0] d);
      logic [4:0]        nib;
      logic              prev;
      search_report_type rep;
      case (op)
         hps_pkg::OP_HEX_CHAR: begin
            if (!pat_loading) start_pattern();
            nib = char_value(d);
            if (!pat_broken) begin
               if (!nib[4]) begin
                  pat_broken = 1'b1;
               end else if (!half_pending) begin
                  half_nibble  = nib[3:0];
                  half_pending = 1'b1;
               end else begin
                  half_pending = 1'b0;
                  // completing a byte past capacity drops it and spoils the pattern
                  if (pat_len >= hps_pkg::MAX_BYTES) begin
                     pat_broken = 1'b1;
                  end else begin
                     pat_bytes[pat_len] = {half_nibble, nib[3:0]};
                     pat_len++;
                  end
               end
            end
         end
         hps_pkg::OP_PAT_END: begin
            if (!pat_loading) start_pattern();
            pat_armed   = !pat_broken && !half_pending && pat_len > 0;
            pat_loading = 1'b0;
            clear_match();
            rep = '{hps_pkg::KIND_STATUS, pat_armed, 7'(pat_len), 1'b0};
            pending_reports.push_back(rep);
         end
         hps_pkg::OP_DATA_BYTE: begin
            if (pat_armed && pat_len > 0) begin
               // high positions first so each one sees the previous beat's bit
               for (int k = pat_len - 1; k >= 0; k--) begin
                  prev = (k == 0) ? 1'b1 : match_bits[k-1];
                  match_bits[k] = prev && (pat_bytes[k] == d);
               end
               if (match_bits[pat_len-1]) hit_flag = 1'b1;
            end
         end
         default: begin
            rep = '{hps_pkg::KIND_RESULT, pat_armed, 7'(pat_len), pat_armed && hit_flag};
            pending_reports.push_back(rep);
            clear_match();
         end
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input hps_pkg::op_type op, input logic [7:0] d);
      if (!steady && $urandom_range(0, 11) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.data  <= d;
      do @(posedge clock); while (!req_bus.ready);
      predict_beat(op, d);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   function automatic byte_list_type random_bytes(input int n, input bit narrow,
                                                  input logic [7:0] a0, input logic [7:0] a1);
      byte_list_type q;
      for (int i = 0; i < n; i++) begin
         q.push_back(narrow ? ($urandom_range(0, 1) ? a1 : a0) : 8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   function automatic int pattern_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 6);
      if (r < 96) return $urandom_range(7, 24);
      return $urandom_range(56, 64);
   endfunction

   task automatic send_pattern(input byte_list_type b);
      foreach (b[i]) begin
         send_beat(hps_pkg::OP_HEX_CHAR, hex_char(b[i][7:4], 1'($urandom_range(0, 1))));
         send_beat(hps_pkg::OP_HEX_CHAR, hex_char(b[i][3:0], 1'($urandom_range(0, 1))));
      end
   endtask

   task automatic send_data(input byte_list_type b);
      foreach (b[i]) send_beat(hps_pkg::OP_DATA_BYTE, b[i]);
   endtask

   // filler, then the pattern whole, short by one byte, or absent, then filler
   task automatic send_segment(input byte_list_type pat, input bit narrow,
                               input logic [7:0] a0, input logic [7:0] a1);
      byte_list_type seg;
      int            pick;
      seg  = random_bytes($urandom_range(0, 10), narrow, a0, a1);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         seg = {seg, pat};
      end else if (pick < 7 && pat.size() > 1) begin
         seg = {seg, pat[0:$-1]};
      end
      seg = {seg, random_bytes($urandom_range(0, 10), narrow, a0, a1)};
      send_data(seg);
      send_beat(hps_pkg::OP_DATA_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_clean_session();
      byte_list_type pat;
      bit            narrow;
      logic [7:0]    a0, a1;
      narrow = 1'($urandom_range(0, 1));
      a0     = 8'($urandom_range(0, 255));
      a1     = 8'($urandom_range(0, 255));
      pat    = random_bytes(pattern_size(), narrow, a0, a1);
      send_pattern(pat);
      send_beat(hps_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 7) == 0) begin
            send_beat(hps_pkg::OP_DATA_END, 8'($urandom_range(0, 255)));
         end else begin
            send_segment(pat, narrow, a0, a1);
         end
      end
   endtask

   task automatic run_broken_session();
      byte_list_type pat;
      int            cut;
      logic [7:0]    junk;
      case ($urandom_range(0, 3))
         0: begin
            pat = random_bytes($urandom_range(0, 6), 1'b0, 8'd0, 8'd0);
            send_pattern(pat);
            send_beat(hps_pkg::OP_HEX_CHAR,
                      hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
         end
         1: begin
            pat = random_bytes($urandom_range(1, 6), 1'b0, 8'd0, 8'd0);
            cut = $urandom_range(0, pat.size());
            send_pattern(pat[0:cut-1]);
            if ($urandom_range(0, 1)) send_beat(hps_pkg::OP_HEX_CHAR, "c");
            do junk = 8'($urandom_range(0, 255)); while (char_value(junk) != 5'd0);
            send_beat(hps_pkg::OP_HEX_CHAR, junk);
            // characters after a bad one are ignored
            send_pattern(pat[cut:$]);
         end
         2: begin
            if ($urandom_range(0, 2) == 0) begin
               pat = random_bytes($urandom_range(65, 66), 1'b0, 8'd0, 8'd0);
               send_pattern(pat);
            end else begin
               send_beat(hps_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
            end
         end
         default: begin
            // close whatever is open so the next pattern end finds none
            send_beat(hps_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
         end
      endcase
      send_beat(hps_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
      send_segment(pat, 1'b0, 8'd0, 8'd0);
   endtask

   task automatic run_early_data_session();
      byte_list_type pat;
      int            split;
      bit            narrow;
      logic [7:0]    a0, a1;
      narrow = 1'($urandom_range(0, 1));
      a0     = 8'($urandom_range(0, 255));
      a1     = 8'($urandom_range(0, 255));
      pat    = random_bytes($urandom_range(1, 6), narrow, a0, a1);
      split  = $urandom_range(0, pat.size());
      send_pattern(pat[0:split-1]);
      send_data({random_bytes($urandom_range(0, 4), narrow, a0, a1), pat});
      send_beat(hps_pkg::OP_DATA_END, 8'($urandom_range(0, 255)));
      send_pattern(pat[split:$]);
      send_beat(hps_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
      send_segment(pat, narrow, a0, a1);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 10)) begin
         send_beat(hps_pkg::op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_early_ends();
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
      send_beat(hps_pkg::OP_DATA_BYTE, 8'h00);
      send_beat(hps_pkg::OP_DATA_END, 8'hFF);
   endtask

   task automatic test_hex_extremes();
      send_beat(hps_pkg::OP_HEX_CHAR, "0");
      send_beat(hps_pkg::OP_HEX_CHAR, "0");
      send_beat(hps_pkg::OP_HEX_CHAR, "f");
      send_beat(hps_pkg::OP_HEX_CHAR, "F");
      send_beat(hps_pkg::OP_PAT_END, 8'hFF);
      send_beat(hps_pkg::OP_DATA_BYTE, 8'h00);
      send_beat(hps_pkg::OP_DATA_BYTE, 8'hFF);
      send_beat(hps_pkg::OP_DATA_END, 8'h00);
   endtask

   task automatic test_bad_chars();
      send_beat(hps_pkg::OP_HEX_CHAR, "1");
      send_beat(hps_pkg::OP_HEX_CHAR, 8'h00);
      send_beat(hps_pkg::OP_HEX_CHAR, "2");
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
      send_beat(hps_pkg::OP_HEX_CHAR, "a");
      send_beat(hps_pkg::OP_HEX_CHAR, "B");
      send_beat(hps_pkg::OP_HEX_CHAR, 8'hFF);
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
   endtask

   task automatic test_odd_length();
      send_beat(hps_pkg::OP_HEX_CHAR, "7");
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
      send_beat(hps_pkg::OP_DATA_BYTE, 8'h70);
      send_beat(hps_pkg::OP_DATA_END, 8'h00);
   endtask

   task automatic test_capacity();
      byte_list_type pat;
      pat = random_bytes(hps_pkg::MAX_BYTES, 1'b0, 8'd0, 8'd0);
      send_pattern(pat);
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
      send_data({random_bytes(3, 1'b0, 8'd0, 8'd0), pat});
      send_beat(hps_pkg::OP_DATA_END, 8'h00);
      wait_drained();
      pat = random_bytes(hps_pkg::MAX_BYTES + 1, 1'b0, 8'd0, 8'd0);
      send_pattern(pat);
      send_beat(hps_pkg::OP_PAT_END, 8'h00);
      send_beat(hps_pkg::OP_DATA_END, 8'h00);
      wait_drained();
   endtask

   task automatic test_random_sessions();
      int pick;
      while (beats_sent < BEAT_TARGET - STEADY_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) run_clean_session();
         else if (pick < 80) run_broken_session();
         else if (pick < 90) run_early_data_session();
         else run_noise();
         if ($urandom_range(0, 49) == 0) wait_drained();
      end
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      while (beats_sent < BEAT_TARGET) run_clean_session();
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op    = hps_pkg::OP_HEX_CHAR;
      req_bus.data  = 8'h00;
      steady        = 1'b0;
      failures      = 0;
      beats_sent    = 0;
      pat_bytes     = '{default: 8'h00};
      start_pattern();
      pat_loading   = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_early_ends();
      test_hex_extremes();
      test_bad_chars();
      test_odd_length();
      wait_drained();
      test_capacity();
      test_random_sessions();
      test_steady_stream();

      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!steady && !reset && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic check_field(input string name, input int want, input logic [6:0] got);
      if ($isunknown(got) || int'(got) != want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      search_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            $error("response beat with nothing expected: kind %0d", rsp_bus.kind);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("kind", int'(want.kind), 7'(rsp_bus.kind));
            check_field("pattern_ok", int'(want.ok), 7'(rsp_bus.pattern_ok));
            check_field("pattern_bytes_used", int'(want.used), rsp_bus.pattern_bytes_used);
            check_field("found", int'(want.found), 7'(rsp_bus.found));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
